// File: rtl/pss_pkg.sv
`default_nettype none

package pss_pkg;

    // Field widths fixed by the request and response formats
    localparam int POS_W        = 5;
    localparam int VAL_W        = 64;
    localparam int CNT_OUT_W    = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_READ   = 2'd2,
        ACT_DELETE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Datapath operation chosen by the controller
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    // Result register occupancy
    typedef enum logic {
        S_EMPTY = 1'b0,
        S_HOLD  = 1'b1
    } t_state;

    typedef struct packed {
        t_action                  action;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        logic [CNT_OUT_W-1:0]     count;
        t_status                  status;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        t_op     op;
        logic    use_tail;
        t_status status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic pos_gt_count;
        logic pos_ge_count;
    } t_flags;

endpackage

`default_nettype wire

// File: rtl/pss_if.sv
`default_nettype none

// Request channel
interface pss_req_if
    import pss_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Response channel
interface pss_rsp_if
    import pss_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/pss_ctrl.sv
`default_nettype none

module pss_ctrl
    import pss_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_action i_action,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_flags  i_flags,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, handshake and command decode
    always_comb begin
        // refuse requests while reset is held
        o_in_ready   = i_rst_n && ((r_state == S_EMPTY) || i_out_ready);
        o_out_valid  = (r_state == S_HOLD);
        accept       = i_in_valid && o_in_ready;

        o_cmd.load     = accept;
        o_cmd.op       = OP_NONE;
        o_cmd.use_tail = 1'b0;
        o_cmd.status   = ST_OK;

        // validate the request against the current length
        case (i_action)
            ACT_APPEND: begin
                if (i_flags.full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.op       = OP_WRITE;
                    o_cmd.use_tail = 1'b1;
                end
            end
            ACT_INSERT: begin
                if (i_flags.pos_gt_count) begin
                    o_cmd.status = ST_RANGE;
                end else if (i_flags.full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.op = OP_WRITE;
                end
            end
            ACT_READ: begin
                if (i_flags.pos_ge_count) begin
                    o_cmd.status = ST_RANGE;
                end else begin
                    o_cmd.op = OP_READ;
                end
            end
            ACT_DELETE: begin
                if (i_flags.pos_ge_count) begin
                    o_cmd.status = ST_RANGE;
                end else begin
                    o_cmd.op = OP_DELETE;
                end
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase

        // drop the operation when nothing is accepted
        if (!accept) begin
            o_cmd.op = OP_NONE;
        end

        // hold the result until taken
        case (r_state)
            S_EMPTY: n_state = accept ? S_HOLD : S_EMPTY;
            S_HOLD:  n_state = (i_out_ready && !accept) ? S_EMPTY : S_HOLD;
            default: n_state = S_EMPTY;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pss_datapath.sv
`default_nettype none

module pss_datapath
    import pss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [VAL_W-1:0]  i_value,
    input  wire t_cmd                     i_cmd,
    output t_flags                        o_flags,
    output t_rsp                          o_rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic signed [VAL_W-1:0] r_cell [CAPACITY];
    logic signed [VAL_W-1:0] n_cell [CAPACITY];
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    t_rsp                    r_rsp;
    t_rsp                    n_rsp;

    logic [CMPW-1:0]         pos_x;
    logic [CMPW-1:0]         cnt_x;
    logic [CMPW-1:0]         wpos_x;
    logic [CMPW-1:0]         n_count_x;
    logic signed [VAL_W-1:0] sel_value;

    // Compare position and length at a common width
    always_comb begin
        pos_x   = CMPW'(i_position);
        cnt_x   = CMPW'(r_count);
        wpos_x  = i_cmd.use_tail ? cnt_x : pos_x;
        o_flags.full         = (r_count == CW'(CAPACITY));
        o_flags.pos_gt_count = (pos_x > cnt_x);
        o_flags.pos_ge_count = (pos_x >= cnt_x);
    end

    // Cell chain: each cell takes its value, its neighbour's or holds
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        always_comb begin
            n_cell[i] = r_cell[i];
            case (i_cmd.op)
                OP_WRITE: begin
                    if (CMPW'(i) == wpos_x) begin
                        n_cell[i] = i_value;
                    end else if (CMPW'(i) > wpos_x) begin
                        n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                    end
                end
                OP_DELETE: begin
                    if ((CMPW'(i) >= pos_x) && (i < CAPACITY - 1)) begin
                        n_cell[i] = r_cell[(i < CAPACITY - 1) ? i + 1 : i];
                    end
                end
                default: begin
                    n_cell[i] = r_cell[i];
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // Length update and result capture
    always_comb begin
        sel_value = r_cell[pos_x[IW-1:0]];
        case (i_cmd.op)
            OP_WRITE:  n_count = r_count + CW'(1);
            OP_DELETE: n_count = r_count - CW'(1);
            default:   n_count = r_count;
        endcase
        n_count_x = CMPW'(n_count);

        n_rsp = r_rsp;
        if (i_cmd.load) begin
            n_rsp.read_value = ((i_cmd.op == OP_READ) || (i_cmd.op == OP_DELETE))
                               ? sel_value : '0;
            n_rsp.count      = n_count_x[CNT_OUT_W-1:0];
            n_rsp.status     = i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// File: rtl/positional_sequence_store_unit.sv
`default_nettype none

// Channel   Dir  Transaction
// i_req     in   action, position, value
// o_rsp     out  read_value, count, status
//
// Each transaction is executed in the cycle it is accepted: the cell chain
// shifts every element at or past the position in that same cycle, so one
// request per cycle is sustained while responses are taken. The result is
// ready in the next cycle in the output register; a new request is accepted
// while it waits if it is taken in the same cycle. Reset clears the length
// and the output valid only. The store itself needs no clearing.

module positional_sequence_store_unit
    import pss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pss_req_if.sink    i_req,
    pss_rsp_if.source  o_rsp
);

    t_cmd   cmd;
    t_flags flags;
    t_rsp   rsp;
    logic   in_ready;
    logic   out_valid;

    pss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_action    (i_req.data.action),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    pss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_position (i_req.data.position),
        .i_value    (i_req.data.value),
        .i_cmd      (cmd),
        .o_flags    (flags),
        .o_rsp      (rsp)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp;

endmodule

`default_nettype wire

// File: tb/sv/positional_sequence_store_unit_test.sv
`timescale 1ns / 1ps

module positional_sequence_store_unit_test;
    import pss_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int END_WAIT     = 2000;
    localparam int MAX_PRINTED  = 40;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_PULSE
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    pss_req_if req_if ();
    pss_rsp_if rsp_if ();

    positional_sequence_store_unit #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the sequence, updated as each request is accepted
    logic signed [VAL_W-1:0] shadow_seq [CAPACITY];
    int                      shadow_len;
    t_rsp                    pending_rsp [$];

    int  mismatch_count;
    int  req_sent;
    int  rsp_checked;
    int  full_hits;
    int  range_hits;
    int  cycle_count;
    bit  drift_up;
    bit  hold_off_req;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: end the run if it overruns
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, pending_rsp.size());
        $display("TB_ERROR");
        $finish;
    end

    // Print one line per mismatch (up to a cap) and count it
    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at response %0d, %s: got %h expected %h",
                     rsp_checked, field, got, want);
    endtask

    // Apply one request to the shadow sequence and return its response
    function automatic t_rsp apply_request(t_req req);
        t_rsp rsp;
        int   pos;
        int   i;
        rsp.read_value = '0;
        rsp.status     = ST_OK;
        pos            = int'(req.position);
        case (req.action)
            ACT_APPEND: begin
                if (shadow_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    shadow_seq[shadow_len] = req.value;
                    shadow_len++;
                end
            end
            ACT_INSERT: begin
                // Range check takes priority over the full check
                if (pos > shadow_len) begin
                    rsp.status = ST_RANGE;
                end else if (shadow_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_seq[i] = shadow_seq[i-1];
                    shadow_seq[pos] = req.value;
                    shadow_len++;
                end
            end
            ACT_READ: begin
                if (pos >= shadow_len)
                    rsp.status = ST_RANGE;
                else
                    rsp.read_value = shadow_seq[pos];
            end
            default: begin
                if (pos >= shadow_len) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.read_value = shadow_seq[pos];
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_seq[i] = shadow_seq[i+1];
                    shadow_len--;
                end
            end
        endcase
        if (rsp.status == ST_FULL)
            full_hits++;
        if (rsp.status == ST_RANGE)
            range_hits++;
        rsp.count = CNT_OUT_W'(shadow_len);
        return rsp;
    endfunction

    // Offer one request and hold it until accepted, then record its response
    task automatic send_request(t_action act, logic [POS_W-1:0] pos,
                                logic signed [VAL_W-1:0] val);
        t_req req;
        req.action   = act;
        req.position = pos;
        req.value    = val;
        req_if.valid <= 1'b1;
        req_if.data  <= req;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        pending_rsp.push_back(apply_request(req));
        req_sent++;
    endtask

    // Drop valid for a number of cycles
    task automatic idle_sender(int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait until every response has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_rsp.size() != 0);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] val;
        case ($urandom_range(0, 9))
            0: val = {1'b0, {(VAL_W-1){1'b1}}};
            1: val = {1'b1, {(VAL_W-1){1'b0}}};
            2: val = '0;
            3: val = '1;
            4: begin
                val = VAL_W'($urandom_range(0, 63));
                val = val - VAL_W'(32);
            end
            default: val = {$urandom, $urandom};
        endcase
        return val;
    endfunction

    // Lean towards growth or shrinkage so both ends of the range are visited
    function automatic t_action pick_action();
        int roll;
        roll = $urandom_range(0, 99);
        if (drift_up) begin
            if (roll < 30) return ACT_APPEND;
            if (roll < 65) return ACT_INSERT;
            if (roll < 80) return ACT_READ;
            return ACT_DELETE;
        end
        if (roll < 10) return ACT_APPEND;
        if (roll < 25) return ACT_INSERT;
        if (roll < 45) return ACT_READ;
        return ACT_DELETE;
    endfunction

    // Mostly in-range positions, with some anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(t_action act);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return POS_W'($urandom_range(0, 31));
        case (act)
            ACT_INSERT: begin
                if (roll < 30)
                    return POS_W'(shadow_len);
                return POS_W'($urandom_range(0, shadow_len));
            end
            default: begin
                if (shadow_len == 0)
                    return '0;
                return POS_W'($urandom_range(0, shadow_len - 1));
            end
        endcase
    endfunction

    // Receiver: stall on a pattern that changes mode now and then
    initial begin : rx_stall
        t_rx_mode mode;
        int       mode_left;
        int       phase;
        int       held;
        rsp_if.ready <= 1'b0;
        mode      = RX_STEADY;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                // Hold off for a long stretch so the block backs up
                rsp_if.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 160);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_STEADY: rsp_if.ready <= 1'b1;
                    RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_if.ready <= ((phase % 5) < 3);
                endcase
            end
        end
    end

    // Compare each response with the oldest outstanding one
    always @(posedge i_clk) begin : rsp_check
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", got.read_value, '0);
            end else begin
                want = pending_rsp.pop_front();
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", got.read_value, want.read_value);
                if (got.count !== want.count)
                    report_mismatch("count", 64'(got.count), 64'(want.count));
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
            end
            rsp_checked++;
        end
    end

    // Requests against an empty store
    task automatic test_empty_store();
        send_request(ACT_READ,   5'd0,  pick_value());
        send_request(ACT_DELETE, 5'd0,  pick_value());
        send_request(ACT_INSERT, 5'd1,  pick_value());
        send_request(ACT_READ,   5'd31, pick_value());
        send_request(ACT_INSERT, 5'd0,  {1'b1, {(VAL_W-1){1'b0}}});
    endtask

    // Every operation, with inserts at both ends and positions out of range
    task automatic test_edit_ops();
        send_request(ACT_APPEND, 5'd31, {1'b0, {(VAL_W-1){1'b1}}});
        send_request(ACT_APPEND, 5'd0,  '1);
        send_request(ACT_APPEND, 5'd0,  '0);
        send_request(ACT_INSERT, POS_W'(shadow_len), {32{2'b01}});
        send_request(ACT_INSERT, 5'd0,  {32{2'b10}});
        send_request(ACT_INSERT, 5'd2,  pick_value());
        send_request(ACT_INSERT, POS_W'(shadow_len + 1), pick_value());
        send_request(ACT_INSERT, 5'd31, pick_value());
        send_request(ACT_READ,   5'd0,  '0);
        send_request(ACT_READ,   POS_W'(shadow_len - 1), '1);
        send_request(ACT_READ,   POS_W'(shadow_len), '0);
        send_request(ACT_DELETE, 5'd2,  '0);
        send_request(ACT_DELETE, POS_W'(shadow_len - 1), '0);
        send_request(ACT_DELETE, 5'd17, '0);
        send_request(ACT_READ,   5'd2,  '0);
    endtask

    // Fill to capacity, then hit the full and range checks at the top
    task automatic test_full_store();
        while (shadow_len < CAPACITY)
            send_request(($urandom_range(0, 1) != 0) ? ACT_APPEND : ACT_INSERT,
                         POS_W'($urandom_range(0, shadow_len)), pick_value());
        send_request(ACT_APPEND, 5'd0, pick_value());
        send_request(ACT_INSERT, 5'd0, pick_value());
        send_request(ACT_INSERT, POS_W'(CAPACITY), pick_value());
        send_request(ACT_INSERT, POS_W'(CAPACITY + 1), pick_value());
        send_request(ACT_READ,   POS_W'(CAPACITY - 1), '0);
        send_request(ACT_READ,   POS_W'(CAPACITY), '0);
        send_request(ACT_DELETE, POS_W'(CAPACITY - 1), '0);
        send_request(ACT_INSERT, POS_W'(shadow_len), pick_value());
        send_request(ACT_DELETE, 5'd0, '0);
        wait_drained();
    endtask

    // Keep offering requests while the receiver holds off
    task automatic test_backpressure();
        int k;
        t_action act;
        hold_off_req = 1'b1;
        for (k = 0; k < 48; k++) begin
            act = pick_action();
            send_request(act, pick_position(act), pick_value());
        end
        wait_drained();
    endtask

    // Bursts of random requests with random gaps
    task automatic test_random_traffic(int n_items);
        int      k;
        int      burst_left;
        int      gap;
        t_action act;
        burst_left = 0;
        for (k = 0; k < n_items; k++) begin
            // Turn round at the ends of the range, and now and then midway
            if (shadow_len >= CAPACITY)
                drift_up = 1'b0;
            else if (shadow_len == 0)
                drift_up = 1'b1;
            else if ($urandom_range(0, 63) == 0)
                drift_up = !drift_up;
            if (k % 400 == 399)
                wait_drained();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                // Leave one stretch with no gaps at all
                gap = (k >= 200 && k < 320) ? 0 : $urandom_range(0, 6);
                if (gap > 0)
                    idle_sender(gap);
            end
            burst_left--;
            act = pick_action();
            send_request(act, pick_position(act), pick_value());
        end
    endtask

    // Main sequence
    initial begin
        int waited;
        shadow_len     = 0;
        mismatch_count = 0;
        req_sent       = 0;
        rsp_checked    = 0;
        full_hits      = 0;
        range_hits     = 0;
        drift_up       = 1'b1;
        hold_off_req   = 1'b0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_edit_ops();
        test_full_store();
        test_backpressure();
        test_random_traffic(1100);

        // Drain, then allow the pipeline to settle
        req_if.valid <= 1'b0;
        waited = 0;
        while (pending_rsp.size() != 0 && waited < END_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_rsp.size() != 0)
            report_mismatch("responses missing", 64'(pending_rsp.size()), '0);

        $display("Sent %0d requests and checked %0d responses with random stalls",
                 req_sent, rsp_checked);
        $display("Full store hit %0d times, out-of-range position %0d times",
                 full_hits, range_hits);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/pss_pkg.sv
rtl/pss_if.sv
rtl/pss_ctrl.sv
rtl/pss_datapath.sv
rtl/positional_sequence_store_unit.sv
tb/sv/positional_sequence_store_unit_test.sv
